/* hdl/acnce_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// ant colony next-city engine. No dependencies.
package acnce_pkg;

    localparam int CITY_COUNT = 32;
    localparam int ANT_COUNT  = 32;
    localparam int CITY_W     = 5;
    localparam int ANT_W      = 5;
    localparam int PH_DEPTH   = CITY_COUNT * CITY_COUNT;
    localparam int PH_AW      = 10;
    localparam int COORD_W    = 7;
    localparam int PH_W       = 16;
    localparam int D2_W       = 15;
    localparam int W_W        = 32;
    localparam int SUM_W      = 37;
    localparam int RDRAW_W    = 7;
    localparam int LHS_W      = 44;
    localparam int DIV_STEPS  = 15;

    localparam logic [D2_W-1:0] DIVIDEND   = 15'd25600;
    localparam logic [PH_W-1:0] ETA_ZERO   = 16'hFFFF;
    localparam logic [PH_W-1:0] PH_RESET   = 16'd16384;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_GLOBAL = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;

    localparam logic [2:0] CFG_THRESH  = 3'd0;
    localparam logic [2:0] CFG_LRATE   = 3'd1;
    localparam logic [2:0] CFG_GRATE   = 3'd2;
    localparam logic [2:0] CFG_LDEP    = 3'd3;
    localparam logic [2:0] CFG_INITPH  = 3'd4;

    typedef struct packed {
        logic capture;
        logic coord_wr;
        logic start_wr;
        logic sel_cur;
        logic rd_cur;
        logic lat_cur;
        logic p1_init;
        logic lat_j;
        logic div_init;
        logic div_step;
        logic mul;
        logic acc;
        logic j_inc;
        logic sel_best;
        logic lhs_calc;
        logic p2_init;
        logic p2_chk;
        logic mask_upd;
        logic lat_edge;
        logic bl1;
        logic bl2;
        logic bl3;
        logic wr_ab;
        logic wr_ba;
        logic fill_wr;
        logic fill_init;
        logic set_fail;
        logic res_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       mask_full;
        logic       mask_j;
        logic       j_last;
        logic       div_last;
        logic       exploit;
        logic       p2_hit;
        logic       fill_last;
        logic       out_busy;
    } dp_status_t;

endpackage

/* hdl/acnce_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acnce_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/acnce_ctrl.sv */
// Controller state machine for the ant colony next-city engine.
// Depends on acnce_pkg; drives acnce_dp through command/status structs.
module acnce_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  acnce_pkg::dp_status_t  sts,
    output acnce_pkg::ctrl_cmd_t   cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CLR     = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_CUR_RD  = 5'd3;
    localparam logic [4:0] S_CUR_LAT = 5'd4;
    localparam logic [4:0] S_P1_RD   = 5'd5;
    localparam logic [4:0] S_P1_LAT  = 5'd6;
    localparam logic [4:0] S_DIV0    = 5'd7;
    localparam logic [4:0] S_DIV     = 5'd8;
    localparam logic [4:0] S_MUL     = 5'd9;
    localparam logic [4:0] S_ACC     = 5'd10;
    localparam logic [4:0] S_END1    = 5'd11;
    localparam logic [4:0] S_P2_RD   = 5'd12;
    localparam logic [4:0] S_P2_CHK  = 5'd13;
    localparam logic [4:0] S_UPD_RD  = 5'd14;
    localparam logic [4:0] S_UPD_LAT = 5'd15;
    localparam logic [4:0] S_BL1     = 5'd16;
    localparam logic [4:0] S_BL2     = 5'd17;
    localparam logic [4:0] S_BL3     = 5'd18;
    localparam logic [4:0] S_WR_AB   = 5'd19;
    localparam logic [4:0] S_WR_BA   = 5'd20;
    localparam logic [4:0] S_FILL    = 5'd21;
    localparam logic [4:0] S_FIN     = 5'd22;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_CLR: begin
                cmd.fill_wr   = 1'b1;
                cmd.fill_init = 1'b1;
                if (sts.fill_last) begin
                    state_next = S_IDLE;
                end
            end
            S_DISP: begin
                unique case (sts.op)
                    acnce_pkg::OP_LOAD: begin
                        cmd.coord_wr = 1'b1;
                        state_next   = S_FIN;
                    end
                    acnce_pkg::OP_START: begin
                        cmd.start_wr = 1'b1;
                        state_next   = S_FIN;
                    end
                    acnce_pkg::OP_MOVE: begin
                        if (sts.mask_full) begin
                            cmd.set_fail = 1'b1;
                            state_next   = S_FIN;
                        end else begin
                            cmd.sel_cur = 1'b1;
                            state_next  = S_CUR_RD;
                        end
                    end
                    acnce_pkg::OP_GLOBAL: state_next = S_UPD_RD;
                    acnce_pkg::OP_RESET:  state_next = S_FILL;
                    default:              state_next = S_FIN;
                endcase
            end
            S_CUR_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = S_CUR_LAT;
            end
            S_CUR_LAT: begin
                cmd.lat_cur = 1'b1;
                cmd.p1_init = 1'b1;
                state_next  = S_P1_RD;
            end
            S_P1_RD: begin
                if (sts.mask_j) begin
                    if (sts.j_last) begin
                        state_next = S_END1;
                    end else begin
                        cmd.j_inc = 1'b1;
                    end
                end else begin
                    state_next = S_P1_LAT;
                end
            end
            S_P1_LAT: begin
                cmd.lat_j  = 1'b1;
                state_next = S_DIV0;
            end
            S_DIV0: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                if (sts.j_last) begin
                    state_next = S_END1;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_END1: begin
                if (sts.exploit) begin
                    cmd.sel_best = 1'b1;
                    state_next   = S_UPD_RD;
                end else begin
                    cmd.lhs_calc = 1'b1;
                    cmd.p2_init  = 1'b1;
                    state_next   = S_P2_RD;
                end
            end
            S_P2_RD: state_next = S_P2_CHK;
            S_P2_CHK: begin
                cmd.p2_chk = 1'b1;
                if (sts.p2_hit || sts.j_last) begin
                    state_next = S_UPD_RD;
                end else begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_P2_RD;
                end
            end
            S_UPD_RD: begin
                cmd.mask_upd = (sts.op == acnce_pkg::OP_MOVE);
                state_next   = S_UPD_LAT;
            end
            S_UPD_LAT: begin
                cmd.lat_edge = 1'b1;
                state_next   = S_BL1;
            end
            S_BL1: begin
                cmd.bl1    = 1'b1;
                state_next = S_BL2;
            end
            S_BL2: begin
                cmd.bl2    = 1'b1;
                state_next = S_BL3;
            end
            S_BL3: begin
                cmd.bl3    = 1'b1;
                state_next = S_WR_AB;
            end
            S_WR_AB: begin
                cmd.wr_ab  = 1'b1;
                state_next = S_WR_BA;
            end
            S_WR_BA: begin
                cmd.wr_ba  = 1'b1;
                state_next = S_FIN;
            end
            S_FILL: begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* hdl/acnce_dp.sv */
// Datapath of the ant colony next-city engine: configuration, ant state,
// RAMs, distance divider, weight accumulation, roulette scan and blend.
// Depends on acnce_pkg and acnce_ram.
module acnce_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [2:0]             s_opcode,
    input  logic [4:0]             s_ant_index,
    input  logic [4:0]             s_city_a,
    input  logic [4:0]             s_city_b,
    input  logic [6:0]             s_coord_x,
    input  logic [6:0]             s_coord_y,
    input  logic [9:0]             s_exploit_draw,
    input  logic [6:0]             s_roulette_draw,
    input  logic [15:0]            s_deposit,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_wr_data,
    input  acnce_pkg::ctrl_cmd_t   cmd,
    output acnce_pkg::dp_status_t  sts,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [4:0]             m_next_city,
    output logic                   m_status
);

    localparam int CW = acnce_pkg::CITY_W;

    // request fields
    logic [2:0]  op_reg;
    logic [acnce_pkg::ANT_W-1:0] ant_reg;
    logic [CW-1:0] ca_reg, cb_reg;
    logic [6:0]  cx_reg, cy_reg, rdraw_reg;
    logic [9:0]  edraw_reg;
    logic [15:0] dep_reg;

    // configuration
    logic [9:0]  thresh_reg;
    logic [15:0] lrate_reg, grate_reg, ldep_reg, initph_reg;

    // ant state
    logic [acnce_pkg::CITY_COUNT-1:0] visited_reg [acnce_pkg::ANT_COUNT];
    logic [CW-1:0] curcity_reg [acnce_pkg::ANT_COUNT];

    // move datapath
    logic [CW-1:0] cur_reg, j_reg, best_reg, last_reg, next_reg;
    logic [6:0]  curx_reg, cury_reg;
    logic [15:0] pher_q;
    logic [acnce_pkg::D2_W-1:0] d2_reg, rem_reg, quo_reg;
    logic [3:0]  dstep_reg;
    logic [acnce_pkg::W_W-1:0]   w_reg, best_w_reg;
    logic [acnce_pkg::SUM_W-1:0] sum_reg, cum_reg;
    logic        any_reg;
    logic [acnce_pkg::LHS_W-1:0] lhs_reg;
    logic [32:0] prod1_reg;
    logic [31:0] prod2_reg;
    logic [15:0] blend_reg;
    logic        fail_reg;
    logic [acnce_pkg::PH_AW-1:0] fill_cnt_reg;
    logic        m_valid_reg;
    logic [4:0]  m_next_reg;
    logic        m_status_reg;

    // RAM ports
    logic [13:0] coord_rdata;
    logic [4:0]  coord_raddr;
    logic        coord_we;
    logic [4:0]  coord_waddr;
    logic [13:0] coord_wdata;
    logic        ph_we;
    logic [acnce_pkg::PH_AW-1:0] ph_waddr, ph_raddr;
    logic [15:0] ph_wdata, ph_rdata;
    logic [acnce_pkg::W_W-1:0] w_rdata;

    logic [acnce_pkg::CITY_COUNT-1:0] mask_w;
    logic        is_move;
    logic [CW-1:0] ea, eb;
    logic [15:0] rate_w, amount_w;
    logic [6:0]  xj, yj, adx, ady;
    logic [acnce_pkg::D2_W-1:0] d2_w;
    logic [acnce_pkg::D2_W:0]   rem_sh;
    logic        qbit;
    logic [15:0] eta_w;
    logic [acnce_pkg::SUM_W-1:0] cum_n;
    logic [acnce_pkg::LHS_W-1:0] cum100;

    assign mask_w  = visited_reg[ant_reg];
    assign is_move = (op_reg == acnce_pkg::OP_MOVE);
    assign ea      = is_move ? next_reg : ca_reg;
    assign eb      = is_move ? cur_reg  : cb_reg;
    assign rate_w   = is_move ? lrate_reg : grate_reg;
    assign amount_w = is_move ? ldep_reg  : dep_reg;

    assign xj  = coord_rdata[13:7];
    assign yj  = coord_rdata[6:0];
    assign adx = (curx_reg >= xj) ? (curx_reg - xj) : (xj - curx_reg);
    assign ady = (cury_reg >= yj) ? (cury_reg - yj) : (yj - cury_reg);
    assign d2_w = acnce_pkg::D2_W'(adx) * acnce_pkg::D2_W'(adx)
                + acnce_pkg::D2_W'(ady) * acnce_pkg::D2_W'(ady);

    assign rem_sh = {rem_reg, acnce_pkg::DIVIDEND[dstep_reg]};
    assign qbit   = (rem_sh >= {1'b0, d2_reg});
    assign eta_w  = (d2_reg == '0) ? acnce_pkg::ETA_ZERO : {1'b0, quo_reg};

    assign cum_n  = cum_reg + acnce_pkg::SUM_W'(w_rdata);
    assign cum100 = (acnce_pkg::LHS_W'(cum_n) << 6) + (acnce_pkg::LHS_W'(cum_n) << 5)
                  + (acnce_pkg::LHS_W'(cum_n) << 2);

    assign sts.op        = op_reg;
    assign sts.mask_full = &mask_w;
    assign sts.mask_j    = mask_w[j_reg];
    assign sts.j_last    = (j_reg == CW'(acnce_pkg::CITY_COUNT - 1));
    assign sts.div_last  = (dstep_reg == '0);
    assign sts.exploit   = (edraw_reg < thresh_reg);
    assign sts.p2_hit    = !mask_w[j_reg] && (lhs_reg <= cum100);
    assign sts.fill_last = (&fill_cnt_reg);
    assign sts.out_busy  = m_valid_reg && !m_ready;

    assign coord_raddr = cmd.rd_cur ? cur_reg : j_reg;
    assign coord_we    = cmd.coord_wr || cmd.fill_init;
    assign coord_waddr = cmd.fill_init ? fill_cnt_reg[4:0] : ca_reg;
    assign coord_wdata = cmd.fill_init ? '0 : {cx_reg, cy_reg};
    assign ph_raddr    = cmd.mask_upd || (cmd.lat_edge == 1'b0 && !is_move) ?
                         {ea, eb} : {cur_reg, j_reg};

    always_comb begin
        ph_we    = cmd.fill_wr || cmd.wr_ab || cmd.wr_ba;
        ph_waddr = {ea, eb};
        ph_wdata = blend_reg;
        if (cmd.fill_wr) begin
            ph_waddr = fill_cnt_reg;
            ph_wdata = cmd.fill_init ? acnce_pkg::PH_RESET : initph_reg;
        end else if (cmd.wr_ba) begin
            ph_waddr = {eb, ea};
        end
    end

    acnce_ram #(.DATA_W(14), .DEPTH(acnce_pkg::CITY_COUNT)) u_coord_ram (
        .aclk  (aclk),
        .we    (coord_we),
        .waddr (coord_waddr),
        .wdata (coord_wdata),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    acnce_ram #(.DATA_W(acnce_pkg::PH_W), .DEPTH(acnce_pkg::PH_DEPTH)) u_pher_ram (
        .aclk  (aclk),
        .we    (ph_we),
        .waddr (ph_waddr),
        .wdata (ph_wdata),
        .raddr (ph_raddr),
        .rdata (ph_rdata)
    );

    acnce_ram #(.DATA_W(acnce_pkg::W_W), .DEPTH(acnce_pkg::CITY_COUNT)) u_weight_ram (
        .aclk  (aclk),
        .we    (cmd.acc),
        .waddr (j_reg),
        .wdata (w_reg),
        .raddr (j_reg),
        .rdata (w_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= 10'd700;
            lrate_reg    <= 16'd6554;
            grate_reg    <= 16'd6554;
            ldep_reg     <= 16'd16384;
            initph_reg   <= 16'd16384;
            fill_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int a = 0; a < acnce_pkg::ANT_COUNT; a++) begin
                visited_reg[a] <= '0;
                curcity_reg[a] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    acnce_pkg::CFG_THRESH: thresh_reg <= cfg_wr_data[9:0];
                    acnce_pkg::CFG_LRATE:  lrate_reg  <= cfg_wr_data;
                    acnce_pkg::CFG_GRATE:  grate_reg  <= cfg_wr_data;
                    acnce_pkg::CFG_LDEP:   ldep_reg   <= cfg_wr_data;
                    acnce_pkg::CFG_INITPH: initph_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (cmd.fill_wr) begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
            end
            if (cmd.start_wr) begin
                visited_reg[ant_reg] <= acnce_pkg::CITY_COUNT'(1) << ca_reg;
                curcity_reg[ant_reg] <= ca_reg;
            end
            if (cmd.mask_upd) begin
                visited_reg[ant_reg] <= mask_w | (acnce_pkg::CITY_COUNT'(1) << next_reg);
                curcity_reg[ant_reg] <= next_reg;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_opcode;
            ant_reg   <= s_ant_index;
            ca_reg    <= s_city_a;
            cb_reg    <= s_city_b;
            cx_reg    <= s_coord_x;
            cy_reg    <= s_coord_y;
            edraw_reg <= s_exploit_draw;
            rdraw_reg <= s_roulette_draw;
            dep_reg   <= s_deposit;
            fail_reg  <= 1'b0;
        end
        if (cmd.set_fail) begin
            fail_reg <= 1'b1;
        end
        if (cmd.sel_cur) begin
            cur_reg <= curcity_reg[ant_reg];
        end
        if (cmd.lat_cur) begin
            curx_reg <= xj;
            cury_reg <= yj;
        end
        if (cmd.p1_init) begin
            j_reg      <= '0;
            sum_reg    <= '0;
            best_w_reg <= '0;
            best_reg   <= '0;
            last_reg   <= '0;
            any_reg    <= 1'b0;
        end
        if (cmd.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.lat_j) begin
            pher_q <= ph_rdata;
            d2_reg <= d2_w;
        end
        if (cmd.div_init) begin
            rem_reg   <= '0;
            quo_reg   <= '0;
            dstep_reg <= 4'(acnce_pkg::DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            rem_reg   <= qbit ? acnce_pkg::D2_W'(rem_sh - {1'b0, d2_reg})
                              : acnce_pkg::D2_W'(rem_sh);
            quo_reg   <= {quo_reg[acnce_pkg::D2_W-2:0], qbit};
            dstep_reg <= dstep_reg - 1'b1;
        end
        if (cmd.mul) begin
            w_reg <= pher_q * eta_w;
        end
        if (cmd.acc) begin
            sum_reg  <= sum_reg + acnce_pkg::SUM_W'(w_reg);
            if (!any_reg || (w_reg > best_w_reg)) begin
                best_w_reg <= w_reg;
                best_reg   <= j_reg;
            end
            any_reg  <= 1'b1;
            last_reg <= j_reg;
        end
        if (cmd.sel_best) begin
            next_reg <= best_reg;
        end
        if (cmd.lhs_calc) begin
            lhs_reg <= rdraw_reg * sum_reg;
        end
        if (cmd.p2_init) begin
            j_reg    <= '0;
            cum_reg  <= '0;
            next_reg <= last_reg;
        end
        if (cmd.p2_chk) begin
            if (!mask_w[j_reg]) begin
                cum_reg <= cum_n;
            end
            if (sts.p2_hit) begin
                next_reg <= j_reg;
            end
        end
        if (cmd.lat_edge) begin
            pher_q <= ph_rdata;
        end
        if (cmd.bl1) begin
            prod1_reg <= (17'h10000 - {1'b0, rate_w}) * pher_q;
        end
        if (cmd.bl2) begin
            prod2_reg <= rate_w * amount_w;
        end
        if (cmd.bl3) begin
            blend_reg <= 16'((34'(prod1_reg) + 34'(prod2_reg) + 34'd32768) >> 16);
        end
        if (cmd.res_load) begin
            m_next_reg   <= (is_move && !fail_reg) ? next_reg : '0;
            m_status_reg <= fail_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_next_city = m_next_reg;
    assign m_status    = m_status_reg;

endmodule

/* hdl/ant_colony_next_city_engine_core.sv */
// Top level of the ant colony next-city engine: controller plus datapath.
// Depends on acnce_pkg, acnce_ctrl, acnce_dp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  s_       | s_valid / s_ready      | opcode, ant, cities, coords, draws, deposit
//  m_       | m_valid / m_ready      | m_next_city, m_status
//  cfg_     | cfg_wr_en              | cfg_index, cfg_wr_data
//
// Load, start, an unknown opcode and a move with no city left go straight to the
// result; a deposit blends and writes both directions of an edge; a pheromone
// reset writes one RAM word per cycle. A move weighs each unvisited city with a
// 15-step radix-2 divider for eta, skips visited ones, then may walk the cities
// for a roulette pick. After reset a clearing pass runs before s_ready rises.
// A stalled result holds in the output register; the next result waits behind it.
module ant_colony_next_city_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [4:0]  s_ant_index,
    input  logic [4:0]  s_city_a,
    input  logic [4:0]  s_city_b,
    input  logic [6:0]  s_coord_x,
    input  logic [6:0]  s_coord_y,
    input  logic [9:0]  s_exploit_draw,
    input  logic [6:0]  s_roulette_draw,
    input  logic [15:0] s_deposit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_next_city,
    output logic        m_status,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    acnce_pkg::ctrl_cmd_t  cmd;
    acnce_pkg::dp_status_t sts;

    acnce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    acnce_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_opcode        (s_opcode),
        .s_ant_index     (s_ant_index),
        .s_city_a        (s_city_a),
        .s_city_b        (s_city_b),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_exploit_draw  (s_exploit_draw),
        .s_roulette_draw (s_roulette_draw),
        .s_deposit       (s_deposit),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_city     (m_next_city),
        .m_status        (m_status)
    );

endmodule

/* hdl/acnce_checker.sv */
// Port-level checks for the ant colony next-city engine, bound to the top.
// Depends on ant_colony_next_city_engine_core.
module acnce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_next_city,
    input logic       m_status
);

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready) else $error("ready during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("request taken while busy");

    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid) else $error("result too early");

    a_fail_zero_city: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_next_city == 5'd0)) else $error("failed move city");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_next_city) && $stable(m_status)))
        else $error("stalled result changed");

endmodule

bind ant_colony_next_city_engine_core acnce_checker u_acnce_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_next_city (m_next_city),
    .m_status    (m_status)
);
